/* design/osm_pkg.sv */
// ----------------------------------------------------------------------------
// osm_pkg
// Shared types and constants for the order statistic multiset.
// ----------------------------------------------------------------------------
package osm_pkg;

  localparam int unsigned CAPACITY_DEF    = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned RANK_W          = 33;

  localparam logic signed [31:0] NO_PRED = -32'sd2147483647;
  localparam logic signed [31:0] NO_SUCC = 32'sd2147483647;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_RANK   = 3'd1,
    FN_KTH    = 3'd2,
    FN_PRED   = 3'd3,
    FN_SUCC   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  answer_value;
    logic [RANK_W-1:0]   answer_rank;
  } out_t;

endpackage

/* design/order_statistic_multiset.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset
// Sorted multiset of signed 32-bit values held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// One item at a time: each item rotates the whole ring of CAPACITY cells
// once past the single head processor, and a new item is accepted only
// after the previous result beat has been taken.
// Reset: synchronous active-low rst_n empties the store (all cells invalid,
// counts zero, used count zero) and drops any pending result.
module order_statistic_multiset
  import osm_pkg::*;
#(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned USED_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [USED_W-1:0] FULL_CNT = USED_W'(CAPACITY);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // ring of cells: cell 0 is the head, the processor refills the tail
  logic                   c_vld [CAPACITY];
  logic signed [31:0]     c_val [CAPACITY];
  logic [COUNT_WIDTH-1:0] c_cnt [CAPACITY];
  logic                   t_vld;
  logic signed [31:0]     t_val;
  logic [COUNT_WIDTH-1:0] t_cnt;
  logic                   shift_en;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   d_vld;
    logic signed [31:0]     d_val;
    logic [COUNT_WIDTH-1:0] d_cnt;
    if (i == CAPACITY - 1) begin : g_tail
      assign d_vld = t_vld;
      assign d_val = t_val;
      assign d_cnt = t_cnt;
    end else begin : g_mid
      assign d_vld = c_vld[i+1];
      assign d_val = c_val[i+1];
      assign d_cnt = c_cnt[i+1];
    end
    osm_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_vld    (d_vld),
      .d_val    (d_val),
      .d_cnt    (d_cnt),
      .q_vld    (c_vld[i]),
      .q_val    (c_val[i]),
      .q_cnt    (c_cnt[i])
    );
  end

  // control and per-item working registers
  state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [2:0]         func_r;
  logic signed [31:0] opnd_r;
  logic               placed_r, placed_nxt;   // insert settled (placed/bumped/refused)
  logic               moving_r, moving_nxt;   // entries shift up behind new value
  logic               refused_r, refused_nxt; // full store, new value dropped
  logic                   car_vld_r, car_vld_nxt;
  logic signed [31:0]     car_val_r, car_val_nxt;
  logic [COUNT_WIDTH-1:0] car_cnt_r, car_cnt_nxt;
  logic [RANK_W-1:0]  acc_r, acc_nxt;         // rank sum or k-th running sum
  logic signed [31:0] ans_r, ans_nxt;
  logic               hit_r, hit_nxt;
  out_t               out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;

  logic                   h_vld;
  logic signed [31:0]     h_val;
  logic [COUNT_WIDTH-1:0] h_cnt;
  logic                   h_lt, h_eq, h_gt;
  logic [RANK_W:0]        acc_sum;
  logic [RANK_W-1:0]      acc_sat;
  logic [RANK_W-1:0]      k_val;
  logic                   is_full;
  logic                   last_step;
  logic                   take_in;

  assign h_vld = c_vld[0];
  assign h_val = c_val[0];
  assign h_cnt = c_cnt[0];
  assign h_lt  = h_vld && (h_val < opnd_r);
  assign h_eq  = h_vld && (h_val == opnd_r);
  assign h_gt  = h_vld && (h_val > opnd_r);
  assign is_full   = (used_r == FULL_CNT);
  assign last_step = (idx_r == LAST_IDX);
  assign take_in   = in_valid && in_ready;
  assign acc_sum   = {1'b0, acc_r} + (RANK_W + 1)'(h_cnt);
  assign acc_sat   = acc_sum[RANK_W] ? RANK_MAX : acc_sum[RANK_W-1:0];
  assign k_val     = RANK_W'(opnd_r[30:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (take_in) state_nxt = S_SCAN;
      S_SCAN: if (last_step) state_nxt = S_DONE;
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    shift_en = 1'b0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: shift_en = 1'b1;
      S_DONE: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  // head processor: examine cell 0, emit the entry for the tail
  always_comb begin
    idx_nxt     = idx_r;
    used_nxt    = used_r;
    placed_nxt  = placed_r;
    moving_nxt  = moving_r;
    refused_nxt = refused_r;
    car_vld_nxt = car_vld_r;
    car_val_nxt = car_val_r;
    car_cnt_nxt = car_cnt_r;
    acc_nxt     = acc_r;
    ans_nxt     = ans_r;
    hit_nxt     = hit_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    t_vld = h_vld;
    t_val = h_val;
    t_cnt = h_cnt;

    if (take_in) begin
      idx_nxt     = '0;
      placed_nxt  = 1'b0;
      moving_nxt  = 1'b0;
      refused_nxt = 1'b0;
      acc_nxt     = '0;
      hit_nxt     = 1'b0;
      ans_nxt     = (func_t'(in_data.func) == FN_PRED) ? NO_PRED :
                    (func_t'(in_data.func) == FN_SUCC) ? NO_SUCC : 32'sd0;
    end

    if (state_r == S_SCAN) begin
      idx_nxt = idx_r + 1'b1;
      case (func_t'(func_r))
        FN_INSERT: begin
          if (moving_r) begin
            // emit the carried entry, carry the head
            t_vld = car_vld_r;
            t_val = car_val_r;
            t_cnt = car_cnt_r;
            car_vld_nxt = h_vld;
            car_val_nxt = h_val;
            car_cnt_nxt = h_cnt;
          end else if (!placed_r && !h_lt) begin
            placed_nxt = 1'b1;
            if (h_eq) begin
              if (h_cnt != CNT_MAX) t_cnt = h_cnt + 1'b1;
            end else if (is_full) begin
              refused_nxt = 1'b1;
            end else begin
              t_vld = 1'b1;
              t_val = opnd_r;
              t_cnt = COUNT_WIDTH'(1);
              moving_nxt  = 1'b1;
              used_nxt    = used_r + 1'b1;
              car_vld_nxt = h_vld;
              car_val_nxt = h_val;
              car_cnt_nxt = h_cnt;
            end
          end
        end
        FN_RANK: begin
          if (h_lt) acc_nxt = acc_sat;
        end
        FN_KTH: begin
          if (h_vld && !hit_r) begin
            acc_nxt = acc_sat;
            if (!opnd_r[31] && opnd_r != 32'sd0 && k_val <= acc_sat) begin
              hit_nxt = 1'b1;
              ans_nxt = h_val;
            end
          end
        end
        FN_PRED: begin
          if (h_lt) ans_nxt = h_val;
        end
        FN_SUCC: begin
          if (h_gt && !hit_r) begin
            hit_nxt = 1'b1;
            ans_nxt = h_val;
          end
        end
        default: ;
      endcase

      if (last_step) begin
        out_vld_nxt          = 1'b1;
        out_nxt.status       = ST_OK;
        out_nxt.answer_value = 32'sd0;
        out_nxt.answer_rank  = '0;
        case (func_t'(func_r))
          FN_INSERT: begin
            // a new value beyond every stored one meets no larger entry
            if (refused_nxt || (!placed_nxt && is_full)) out_nxt.status = ST_FULL;
          end
          FN_RANK: begin
            out_nxt.answer_rank = (acc_nxt == RANK_MAX) ? RANK_MAX : acc_nxt + 1'b1;
          end
          FN_KTH: begin
            if (hit_nxt) out_nxt.answer_value = ans_nxt;
            else         out_nxt.status = ST_MISSING;
          end
          FN_PRED, FN_SUCC: out_nxt.answer_value = ans_nxt;
          default: ;
        endcase
      end
    end

    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // working registers: loaded on each accepted beat before use
  always_ff @(posedge clk) begin
    if (take_in) begin
      func_r <= in_data.func;
      opnd_r <= in_data.operand;
    end
    idx_r     <= idx_nxt;
    placed_r  <= placed_nxt;
    moving_r  <= moving_nxt;
    refused_r <= refused_nxt;
    car_vld_r <= car_vld_nxt;
    car_val_r <= car_val_nxt;
    car_cnt_r <= car_cnt_nxt;
    acc_r     <= acc_nxt;
    ans_r     <= ans_nxt;
    hit_r     <= hit_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // the store never holds more distinct values than cells
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_CNT) else $error("used count beyond capacity");

  // a result is pending exactly while waiting in the done state
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) == out_vld_r) else $error("result flag out of step");

  // an accepted beat starts a ring rotation from the head
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    take_in |=> (state_r == S_SCAN) && (idx_r == '0)) else $error("scan start");

  // used count grows by at most one per item, never shrinks
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (used_r == $past(used_r)) ||
                            (used_r == $past(used_r) + 1'b1)) else $error("used step");

endmodule

/* design/osm_cell.sv */
// ----------------------------------------------------------------------------
// osm_cell
// One storage cell of the ring: value, repeat count and valid flag.
// ----------------------------------------------------------------------------
module osm_cell
  import osm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift_en,
  input  logic                   d_vld,
  input  logic signed [31:0]     d_val,
  input  logic [COUNT_WIDTH-1:0] d_cnt,
  output logic                   q_vld,
  output logic signed [31:0]     q_val,
  output logic [COUNT_WIDTH-1:0] q_cnt
);

  logic                   vld_r;
  logic signed [31:0]     val_r;
  logic [COUNT_WIDTH-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else if (shift_en) begin
      vld_r <= d_vld;
      cnt_r <= d_cnt;
    end
  end

  // value holds no reset: it is only meaningful where valid is set
  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= d_val;
    end
  end

  assign q_vld = vld_r;
  assign q_val = val_r;
  assign q_cnt = cnt_r;

endmodule

/* bench/order_statistic_multiset_tb.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset_tb
// Drives inserts and rank, k-th, predecessor and successor queries into the
// multiset, predicts every answer from a sorted shadow copy of the store and
// checks each result beat field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module order_statistic_multiset_tb;
  import osm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = CAPACITY_DEF;
  localparam longint      COUNT_TOP = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam longint      RANK_TOP  = (64'd1 << RANK_W) - 1;
  // One item walks the whole ring, so allow generously for the slowest run.
  localparam longint      CYCLE_LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  order_statistic_multiset uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Shadow store: distinct values ascending, with their repeat counts.
  int     sorted_keys[$];
  longint key_counts[$];
  longint element_total = 0;

  out_t   pending_answers[$];
  int     mismatches = 0;
  int     items_sent = 0;
  int     beats_checked = 0;
  int     full_drops = 0;
  int     idle_max = 3;
  int     hold_cycles = 0;
  bit     beat_seen = 0;
  longint cycle_count = 0;

  // Compute the answer to one item and advance the shadow store.
  function automatic out_t predict_answer(logic [2:0] f, int x);
    out_t   r;
    int     pos;
    longint run;
    r = '0;
    pos = 0;
    case (f)
      FN_INSERT: begin
        while (pos < sorted_keys.size() && sorted_keys[pos] < x) pos++;
        if (pos < sorted_keys.size() && sorted_keys[pos] == x) begin
          if (key_counts[pos] < COUNT_TOP) begin
            key_counts[pos]++;
            element_total++;
          end
        end else if (sorted_keys.size() >= SLOTS) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          sorted_keys.insert(pos, x);
          key_counts.insert(pos, 1);
          element_total++;
        end
      end
      FN_RANK: begin
        run = 1;
        while (pos < sorted_keys.size() && sorted_keys[pos] < x) begin
          run += key_counts[pos];
          pos++;
        end
        r.answer_rank = RANK_W'((run > RANK_TOP) ? RANK_TOP : run);
      end
      FN_KTH: begin
        r.status = ST_MISSING;
        run = 0;
        if (x >= 1) begin
          foreach (sorted_keys[i]) begin
            run += key_counts[i];
            if (longint'(x) <= run) begin
              r.status = ST_OK;
              r.answer_value = sorted_keys[i];
              break;
            end
          end
        end
      end
      FN_PRED: begin
        r.answer_value = NO_PRED;
        while (pos < sorted_keys.size() && sorted_keys[pos] < x) begin
          r.answer_value = sorted_keys[pos];
          pos++;
        end
      end
      FN_SUCC: begin
        r.answer_value = NO_SUCC;
        foreach (sorted_keys[i]) begin
          if (sorted_keys[i] > x) begin
            r.answer_value = sorted_keys[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one beat. Call at a rising edge; returns at the edge that took it.
  task automatic send_beat(logic [2:0] f, int x);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {f, x};
    // Ready only moves at rising edges, so the falling edge sees it safely.
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_answers.push_back(predict_answer(f, x));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Random operand: mostly near stored values, sometimes anywhere.
  function automatic int pick_value(int spread);
    int base;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 2 * spread) - spread;
      default: begin
        if (sorted_keys.size() == 0) return $urandom_range(0, 9);
        base = sorted_keys[$urandom_range(0, sorted_keys.size() - 1)];
        return base + $urandom_range(0, 2) - 1;
      end
    endcase
  endfunction

  function automatic int pick_position();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 32'(element_total + 2));
  endfunction

  // Check each result beat against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beat_seen = 1;
      beats_checked++;
      if (pending_answers.size() == 0) begin
        $error("result beat with no item pending: %p", out_data);
        mismatches++;
      end else begin
        out_t e;
        e = pending_answers.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          mismatches++;
        end
        if (out_data.answer_value !== e.answer_value) begin
          $error("answer_value: expected %0d, got %0d", e.answer_value,
                 out_data.answer_value);
          mismatches++;
        end
        if (out_data.answer_rank !== e.answer_rank) begin
          $error("answer_rank: expected %0d, got %0d", e.answer_rank,
                 out_data.answer_rank);
          mismatches++;
        end
      end
    end
  end

  // Result side: a random stall after every beat, plus long hold-offs.
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (beat_seen) begin
      beat_seen = 0;
      stall_left = $urandom_range(0, idle_max);
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Empty store, extremes, duplicates and every function, unknown ones too.
  task automatic test_directed();
    send_beat(FN_RANK, 0);
    send_beat(FN_KTH, 1);
    send_beat(FN_PRED, 0);
    send_beat(FN_SUCC, 0);
    send_beat(FN_INSERT, 32'h8000_0000);
    send_beat(FN_INSERT, 32'h7fff_ffff);
    send_beat(FN_INSERT, 0);
    send_beat(FN_INSERT, 0);
    send_beat(FN_INSERT, -1);
    send_beat(FN_KTH, 0);
    send_beat(FN_KTH, -1);
    send_beat(FN_KTH, 3);
    send_beat(FN_KTH, 5);
    send_beat(FN_KTH, 6);
    send_beat(FN_PRED, 32'h8000_0000);
    send_beat(FN_SUCC, 32'h7fff_ffff);
    send_beat(FN_PRED, 32'h7fff_ffff);
    send_beat(FN_SUCC, 32'h8000_0000);
    send_beat(FN_RANK, 32'h7fff_ffff);
    send_beat(FN_RANK, 32'h8000_0000);
    send_beat(3'd5, -1);
    send_beat(3'd6, 7);
    send_beat(3'd7, 32'h8000_0000);
    wait_drained();
  endtask

  // Hold off the result side while items keep coming, so input stalls.
  task automatic test_backpressure();
    hold_cycles = 4 * SLOTS;
    repeat (4) send_beat(3'($urandom_range(0, 4)), pick_value(50));
    wait_drained();
  endtask

  // Small value range: many repeats and dense queries.
  task automatic test_dense_mix(int n);
    repeat (n) begin
      int         pick;
      logic [2:0] f;
      pick = $urandom_range(0, 11);
      f = (pick > 4) ? FN_INSERT : 3'(pick);
      if ($urandom_range(0, 40) == 0) f = 3'(5 + $urandom_range(0, 2));
      if (f == FN_KTH) send_beat(f, pick_position());
      else send_beat(f, pick_value(30));
    end
  endtask

  // Fill to capacity with distinct values, then keep pushing past it.
  task automatic test_fill_store(int n);
    repeat (n) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) send_beat(FN_INSERT, $urandom());
      else if (pick < 7) send_beat(FN_KTH, pick_position());
      else send_beat(3'(1 + 2 * (pick - 7) + $urandom_range(0, 1)), pick_value(1000));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    idle_max = 0;
    test_dense_mix(150);
    idle_max = 3;
    test_dense_mix(350);
    wait_drained();
    test_fill_store(800);
    test_backpressure();
    wait_drained();
    repeat (SLOTS + 20) @(posedge clk);
    $display("covered %0d items, %0d result beats, %0d distinct values held,",
             items_sent, beats_checked, sorted_keys.size());
    $display("%0d inserts dropped on a full store, %0d mismatches",
             full_drops, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
